// ----- hw/rtl/mt64_pkg.sv -----
// Shared types, constants and word functions of the 64-bit Mersenne Twister generator.
package mt64_pkg;

    localparam int STATE_WORDS  = 312;
    localparam int MID_OFFSET   = 156;
    localparam int KEY_DEPTH_DEF = 512;
    localparam int SW_W         = 9;

    localparam logic [SW_W-1:0] IDX_LAST      = SW_W'(STATE_WORDS - 1);
    localparam logic [SW_W-1:0] IDX_EXHAUSTED = SW_W'(STATE_WORDS);
    localparam logic [SW_W-1:0] IDX_UNSEEDED  = SW_W'(STATE_WORDS + 1);
    localparam logic [SW_W-1:0] IDX_MID       = SW_W'(MID_OFFSET);

    localparam logic [63:0] TWIST_MATRIX = 64'hB5026F5AA96619E9;
    localparam logic [63:0] UPPER_BITS   = 64'hFFFFFFFF80000000;
    localparam logic [63:0] LOWER_BITS   = 64'h000000007FFFFFFF;
    localparam logic [63:0] MUL_SEED_K   = 64'h5851F42D4C957F2D;
    localparam logic [63:0] MUL_KEY1_K   = 64'h369DEA0F31A53F85;
    localparam logic [63:0] MUL_KEY2_K   = 64'h27BB2EE687B0B0FD;
    localparam logic [63:0] KEY_BASE_SEED = 64'd19650218;
    localparam logic [63:0] DEFAULT_SEED = 64'd5489;
    localparam logic [63:0] KEY_FINAL_W0 = 64'h8000000000000000;
    localparam logic [63:0] TEMPER_B     = 64'h5555555555555555;
    localparam logic [63:0] TEMPER_C     = 64'h71D67FFFEDA60000;
    localparam logic [63:0] TEMPER_D     = 64'hFFF7EEE000000000;

    typedef enum logic [1:0] {
        CMD_SEED      = 2'd0,
        CMD_LOAD_KEY  = 2'd1,
        CMD_APPLY_KEY = 2'd2,
        CMD_GENERATE  = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        MUL_SEED,
        MUL_KEY1,
        MUL_KEY2
    } t_mul_sel;

    typedef enum logic [1:0] {
        AFT_IDLE,
        AFT_KEY,
        AFT_GEN
    } t_after;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SD_INIT,
        ST_SD_MUL,
        ST_SD_WAIT,
        ST_K1_INIT,
        ST_K1_RD,
        ST_K1_WAIT,
        ST_K1_WRAP,
        ST_K2_INIT,
        ST_K2_RD,
        ST_K2_WAIT,
        ST_K2_WRAP,
        ST_K_FIN,
        ST_TW_RD0,
        ST_TW_CAP,
        ST_TW_RNX,
        ST_TW_RFR,
        ST_TW_WR,
        ST_GEN_RD,
        ST_GEN_OUT
    } t_state;

    typedef struct packed {
        logic     sd_init;
        logic     sd_step;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     k_init;
        logic     kx_read;
        logic     k1_step;
        logic     k2_init;
        logic     k2_step;
        logic     k_wrap;
        logic     k_fin;
        logic     tw_rd0;
        logic     tw_cap;
        logic     tw_rnx;
        logic     tw_rfr;
        logic     tw_wr;
        logic     gen_rd;
        logic     gen_out;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic i_last;
        logic k_last;
        logic k_zero;
        logic unseeded;
        logic exhausted;
        logic key_empty;
        logic out_free;
    } t_dp_status;

    function automatic logic [63:0] fold_word(input logic [63:0] p);
        return p ^ (p >> 62);
    endfunction

    function automatic logic [63:0] mix_word(input logic [63:0] a, input logic [63:0] b,
                                             input logic [63:0] far);
        logic [63:0] x;
        x = (a & UPPER_BITS) | (b & LOWER_BITS);
        return far ^ (x >> 1) ^ (x[0] ? TWIST_MATRIX : 64'd0);
    endfunction

    function automatic logic [63:0] temper_word(input logic [63:0] w);
        logic [63:0] x;
        x = w;
        x = x ^ ((x >> 29) & TEMPER_B);
        x = x ^ ((x << 17) & TEMPER_C);
        x = x ^ ((x << 37) & TEMPER_D);
        x = x ^ (x >> 43);
        return x;
    endfunction

endpackage

// ----- hw/rtl/mt64_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mt64_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/mt64_mul.sv -----
// Multicycle 64x64 low-half multiplier built on one shared 32x32 multiplier.
module mt64_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);
    logic        r_busy;
    logic [1:0]  r_step;
    logic        r_done;
    logic [63:0] r_x;
    logic [63:0] r_y;
    logic [63:0] r_acc;
    logic [31:0] w_xa;
    logic [31:0] w_ya;
    logic [63:0] w_prod;
    logic [63:0] n_acc;

    // low*low, then the two cross terms shifted into the upper half
    always_comb begin
        case (r_step)
            2'd0: begin
                w_xa = r_x[31:0];
                w_ya = r_y[31:0];
            end
            2'd1: begin
                w_xa = r_x[31:0];
                w_ya = r_y[63:32];
            end
            default: begin
                w_xa = r_x[63:32];
                w_ya = r_y[31:0];
            end
        endcase
        w_prod = {32'd0, w_xa} * {32'd0, w_ya};
        n_acc  = (r_step == 2'd0) ? w_prod : r_acc + {w_prod[31:0], 32'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_a;
            r_y <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ----- hw/rtl/mt64_datapath.sv -----
// Datapath: state and key RAMs, index counters, word arithmetic and output register.
module mt64_datapath #(
    parameter int KEY_DEPTH = mt64_pkg::KEY_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  mt64_pkg::t_command     i_command,
    input  logic [63:0]            i_value,
    input  mt64_pkg::t_dp_cmd      i_cmd,
    output mt64_pkg::t_dp_status   o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [63:0]            o_out_word
);
    import mt64_pkg::*;

    localparam int KAW  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int LENW = $clog2(KEY_DEPTH + 1);
    localparam int KCW  = (LENW > SW_W) ? LENW : SW_W;

    logic [63:0]     r_src;
    logic [63:0]     r_prev;
    logic [63:0]     r_a;
    logic [63:0]     r_b;
    logic [SW_W-1:0] r_i;
    logic [SW_W-1:0] r_idx;
    logic [LENW-1:0] r_j;
    logic [LENW-1:0] r_len;
    logic [KCW-1:0]  r_k;
    logic [63:0]     r_out;
    logic            r_out_valid;

    logic            w_accept;
    logic            w_out_free;
    logic [63:0]     w_srd;
    logic [63:0]     w_krd;
    logic [63:0]     w_prod;
    logic            w_mul_done;
    logic [63:0]     w_mul_k;
    logic            w_swe;
    logic [SW_W-1:0] w_swaddr;
    logic [63:0]     w_swdata;
    logic            w_sre;
    logic [SW_W-1:0] w_sraddr;
    logic            w_kwe;
    logic [SW_W-1:0] w_nx;
    logic [SW_W-1:0] w_fr;
    logic [LENW-1:0] w_j_inc;
    logic [63:0]     n_seed_word;
    logic [63:0]     n_key1_word;
    logic [63:0]     n_key2_word;
    logic [63:0]     n_twist_word;
    logic [SW_W-1:0] n_i_key;

    assign w_accept   = i_in_valid && i_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_nx       = (r_i == IDX_LAST) ? '0 : r_i + SW_W'(1);
    assign w_fr       = (r_i < IDX_MID) ? r_i + IDX_MID : r_i - IDX_MID;
    assign w_j_inc    = r_j + LENW'(1);
    assign n_i_key    = (r_i == IDX_LAST) ? SW_W'(1) : r_i + SW_W'(1);

    assign n_seed_word  = w_prod + 64'(r_i);
    assign n_key1_word  = (w_srd ^ w_prod) + w_krd + 64'(r_j);
    assign n_key2_word  = (w_srd ^ w_prod) - 64'(r_i);
    assign n_twist_word = mix_word(r_a, r_b, w_srd);

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SEED: w_mul_k = MUL_SEED_K;
            MUL_KEY1: w_mul_k = MUL_KEY1_K;
            MUL_KEY2: w_mul_k = MUL_KEY2_K;
            default:  w_mul_k = MUL_SEED_K;
        endcase
    end

    // state RAM write port
    always_comb begin
        w_swe    = 1'b1;
        w_swaddr = r_i;
        w_swdata = n_twist_word;
        if (i_cmd.sd_init) begin
            w_swaddr = '0;
            w_swdata = r_src;
        end else if (i_cmd.sd_step) begin
            w_swdata = n_seed_word;
        end else if (i_cmd.k1_step) begin
            w_swdata = n_key1_word;
        end else if (i_cmd.k2_step) begin
            w_swdata = n_key2_word;
        end else if (i_cmd.k_wrap) begin
            w_swaddr = '0;
            w_swdata = r_prev;
        end else if (i_cmd.k_fin) begin
            w_swaddr = '0;
            w_swdata = KEY_FINAL_W0;
        end else if (!i_cmd.tw_wr) begin
            w_swe = 1'b0;
        end
    end

    // state RAM read port
    always_comb begin
        w_sre    = 1'b1;
        w_sraddr = r_i;
        if (i_cmd.tw_rd0) begin
            w_sraddr = '0;
        end else if (i_cmd.tw_rnx) begin
            w_sraddr = w_nx;
        end else if (i_cmd.tw_rfr) begin
            w_sraddr = w_fr;
        end else if (i_cmd.gen_rd) begin
            w_sraddr = r_idx;
        end else if (!i_cmd.kx_read) begin
            w_sre = 1'b0;
        end
    end

    assign w_kwe = w_accept && (i_command == CMD_LOAD_KEY) && (r_len < LENW'(KEY_DEPTH));

    mt64_ram #(
        .WIDTH (64),
        .DEPTH (STATE_WORDS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_swe),
        .i_waddr (w_swaddr),
        .i_wdata (w_swdata),
        .i_re    (w_sre),
        .i_raddr (w_sraddr),
        .o_rdata (w_srd)
    );

    mt64_ram #(
        .WIDTH (64),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_kwe),
        .i_waddr (r_len[KAW-1:0]),
        .i_wdata (i_value),
        .i_re    (i_cmd.kx_read),
        .i_raddr (r_j[KAW-1:0]),
        .o_rdata (w_krd)
    );

    mt64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (fold_word(r_prev)),
        .i_b     (w_mul_k),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= IDX_UNSEEDED;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_kwe) begin
                r_len <= r_len + LENW'(1);
            end else if (i_cmd.k_fin) begin
                r_len <= '0;
            end
            if ((i_cmd.sd_step && r_i == IDX_LAST) || i_cmd.k_fin) begin
                r_idx <= IDX_EXHAUSTED;
            end else if (i_cmd.tw_wr && r_i == IDX_LAST) begin
                r_idx <= '0;
            end else if (i_cmd.gen_out && w_out_free) begin
                r_idx <= r_idx + SW_W'(1);
            end
            if (i_cmd.gen_out && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            case (i_command)
                CMD_SEED:      r_src <= i_value;
                CMD_APPLY_KEY: r_src <= KEY_BASE_SEED;
                default:       r_src <= DEFAULT_SEED;
            endcase
        end
        if (i_cmd.sd_init) begin
            r_prev <= r_src;
            r_i    <= SW_W'(1);
        end else if (i_cmd.sd_step) begin
            r_prev <= n_seed_word;
            r_i    <= r_i + SW_W'(1);
        end else if (i_cmd.k_init) begin
            r_prev <= r_src;
            r_i    <= SW_W'(1);
            r_j    <= '0;
            r_k    <= (KCW'(r_len) > KCW'(STATE_WORDS)) ? KCW'(r_len) : KCW'(STATE_WORDS);
        end else if (i_cmd.k1_step) begin
            r_prev <= n_key1_word;
            r_i    <= n_i_key;
            r_j    <= (w_j_inc >= r_len) ? '0 : w_j_inc;
            r_k    <= r_k - KCW'(1);
        end else if (i_cmd.k2_init) begin
            r_k    <= KCW'(STATE_WORDS - 1);
        end else if (i_cmd.k2_step) begin
            r_prev <= n_key2_word;
            r_i    <= n_i_key;
            r_k    <= r_k - KCW'(1);
        end else if (i_cmd.tw_rd0) begin
            r_i    <= '0;
        end else if (i_cmd.tw_cap) begin
            r_a    <= w_srd;
        end else if (i_cmd.tw_rfr) begin
            r_b    <= w_srd;
        end else if (i_cmd.tw_wr) begin
            r_a    <= r_b;
            r_i    <= r_i + SW_W'(1);
        end
        if (i_cmd.gen_out && w_out_free) begin
            r_out <= temper_word(w_srd);
        end
    end

    assign o_status.mul_done  = w_mul_done;
    assign o_status.i_last    = (r_i == IDX_LAST);
    assign o_status.k_last    = (r_k == KCW'(1));
    assign o_status.k_zero    = (r_k == '0);
    assign o_status.unseeded  = (r_idx == IDX_UNSEEDED);
    assign o_status.exhausted = (r_idx == IDX_EXHAUSTED);
    assign o_status.key_empty = (r_len == '0);
    assign o_status.out_free  = w_out_free;
    assign o_out_valid        = r_out_valid;
    assign o_out_word         = r_out;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_UNSEEDED) else $error("read index out of range");
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LENW'(KEY_DEPTH)) else $error("key count beyond depth");
    a_key_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.k_fin |=> (r_len == '0) && (r_idx == IDX_EXHAUSTED))
        else $error("apply-key did not leave store empty and state exhausted");
    a_gen_seeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.gen_out && w_out_free) |-> (r_idx < IDX_EXHAUSTED))
        else $error("word emitted from exhausted state");
endmodule

// ----- hw/rtl/mt64_ctrl.sv -----
// Controller state machine sequencing seeding, key seeding, twist and output.
module mt64_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  mt64_pkg::t_command   i_command,
    input  mt64_pkg::t_dp_status i_status,
    output logic                 o_in_ready,
    output mt64_pkg::t_dp_cmd    o_cmd
);
    import mt64_pkg::*;

    t_state r_state;
    t_state n_state;
    t_after r_after;
    t_after n_after;
    logic   w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_after <= AFT_IDLE;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
        end
    end

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_command)
                        CMD_SEED: begin
                            n_after = AFT_IDLE;
                            n_state = ST_SD_INIT;
                        end
                        CMD_APPLY_KEY: begin
                            if (!i_status.key_empty) begin
                                n_after = AFT_KEY;
                                n_state = ST_SD_INIT;
                            end
                        end
                        CMD_GENERATE: begin
                            if (i_status.unseeded) begin
                                n_after = AFT_GEN;
                                n_state = ST_SD_INIT;
                            end else if (i_status.exhausted) begin
                                n_state = ST_TW_RD0;
                            end else begin
                                n_state = ST_GEN_RD;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SD_INIT: n_state = ST_SD_MUL;
            ST_SD_MUL:  n_state = ST_SD_WAIT;
            ST_SD_WAIT: begin
                if (i_status.mul_done) begin
                    if (!i_status.i_last) begin
                        n_state = ST_SD_MUL;
                    end else begin
                        case (r_after)
                            AFT_KEY: n_state = ST_K1_INIT;
                            AFT_GEN: n_state = ST_TW_RD0;
                            default: n_state = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_K1_INIT: n_state = ST_K1_RD;
            ST_K1_RD:   n_state = ST_K1_WAIT;
            ST_K1_WAIT: begin
                if (i_status.mul_done) begin
                    if (i_status.i_last) begin
                        n_state = ST_K1_WRAP;
                    end else if (i_status.k_last) begin
                        n_state = ST_K2_INIT;
                    end else begin
                        n_state = ST_K1_RD;
                    end
                end
            end
            ST_K1_WRAP: n_state = i_status.k_zero ? ST_K2_INIT : ST_K1_RD;
            ST_K2_INIT: n_state = ST_K2_RD;
            ST_K2_RD:   n_state = ST_K2_WAIT;
            ST_K2_WAIT: begin
                if (i_status.mul_done) begin
                    if (i_status.i_last) begin
                        n_state = ST_K2_WRAP;
                    end else if (i_status.k_last) begin
                        n_state = ST_K_FIN;
                    end else begin
                        n_state = ST_K2_RD;
                    end
                end
            end
            ST_K2_WRAP: n_state = i_status.k_zero ? ST_K_FIN : ST_K2_RD;
            ST_K_FIN:   n_state = ST_IDLE;
            ST_TW_RD0:  n_state = ST_TW_CAP;
            ST_TW_CAP:  n_state = ST_TW_RNX;
            ST_TW_RNX:  n_state = ST_TW_RFR;
            ST_TW_RFR:  n_state = ST_TW_WR;
            ST_TW_WR:   n_state = i_status.i_last ? ST_GEN_RD : ST_TW_RNX;
            ST_GEN_RD:  n_state = ST_GEN_OUT;
            ST_GEN_OUT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_SD_INIT: o_cmd.sd_init = 1'b1;
            ST_SD_MUL: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MUL_SEED;
            end
            ST_SD_WAIT: o_cmd.sd_step = i_status.mul_done;
            ST_K1_INIT: o_cmd.k_init = 1'b1;
            ST_K1_RD: begin
                o_cmd.kx_read   = 1'b1;
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MUL_KEY1;
            end
            ST_K1_WAIT: o_cmd.k1_step = i_status.mul_done;
            ST_K1_WRAP: o_cmd.k_wrap = 1'b1;
            ST_K2_INIT: o_cmd.k2_init = 1'b1;
            ST_K2_RD: begin
                o_cmd.kx_read   = 1'b1;
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MUL_KEY2;
            end
            ST_K2_WAIT: o_cmd.k2_step = i_status.mul_done;
            ST_K2_WRAP: o_cmd.k_wrap = 1'b1;
            ST_K_FIN:   o_cmd.k_fin = 1'b1;
            ST_TW_RD0:  o_cmd.tw_rd0 = 1'b1;
            ST_TW_CAP:  o_cmd.tw_cap = 1'b1;
            ST_TW_RNX:  o_cmd.tw_rnx = 1'b1;
            ST_TW_RFR:  o_cmd.tw_rfr = 1'b1;
            ST_TW_WR:   o_cmd.tw_wr = 1'b1;
            ST_GEN_RD:  o_cmd.gen_rd = 1'b1;
            ST_GEN_OUT: o_cmd.gen_out = 1'b1;
            default:    o_cmd = '0;
        endcase
    end
endmodule

// ----- hw/rtl/mersenne_twister_64_generator.sv -----
// Top level of the 64-bit Mersenne Twister (MT19937-64) pseudorandom word generator.
//
// Each input item carries a command in tuser and a 64-bit value in tdata: seed from value,
// load a key word (dropped once KEY_DEPTH words are stored), apply the stored key words
// (ignored when none are stored), or generate. Only generate yields an output item, one
// tempered 64-bit word. Generate before any seeding seeds with 5489 first. The block takes
// one item at a time. Load-key and an ignored apply-key return straight to idle. A generate
// from an unexhausted state reads a state word and tempers it into the output register,
// waiting while that register is full; every 312th word first re-twists the 312-word state
// word by word, limited by the single read port of the state RAM. Seeding from a value
// runs word by word because each word waits on the previous one through a three-step
// 64-bit multiply. Apply-key runs that seeding, then max(key count, 312) + 311 multiply
// steps. An output item waiting in the output register does not block the next input item.
module mersenne_twister_64_generator #(
    parameter int KEY_DEPTH = mt64_pkg::KEY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [63:0] value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // [63:0] random_word
);
    import mt64_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_command   w_command;

    assign w_command = t_command'(i_s_axis_tuser);

    // sequence the long operations
    mt64_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_command  (w_command),
        .i_status   (w_status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // hold the state, key store and output register
    mt64_datapath #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_ready  (o_s_axis_tready),
        .i_command   (w_command),
        .i_value     (i_s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_word  (o_m_axis_tdata)
    );
endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the 64-bit Mersenne Twister word generator.
`timescale 1ns / 1ps

module testbench;
    import mt64_pkg::*;

    localparam int KEY_CAP        = KEY_DEPTH_DEF;
    localparam int STALL_LIMIT    = 40000;  // cycles without any handshake before giving up
    localparam int DRAIN_CYCLES   = 300;
    localparam int RANDOM_ITEMS   = 345;

    typedef struct packed {
        t_command    cmd;
        logic [63:0] value;
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_data = 64'd0;
    t_command    s_cmd = CMD_GENERATE;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_data;

    t_request    request_queue[$];
    logic [63:0] expected_words[$];
    int          error_count = 0;
    int          accepted_count = 0;
    int          quiet_cycles = 0;

    // Shadow generator state
    logic [63:0] twister_q[STATE_WORDS];
    int unsigned word_ptr;
    logic [63:0] key_words[KEY_CAP];
    int unsigned key_fill;

    always #4 i_clk = ~i_clk;

    mersenne_twister_64_generator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [63:0] value
        .i_s_axis_tuser  (s_cmd),    // [1:0] command
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)    // [63:0] random_word
    );

    function automatic void fill_from_seed(input logic [63:0] seed);
        logic [63:0] p;
        twister_q[0] = seed;
        for (int n = 1; n < STATE_WORDS; n++) begin
            p = twister_q[n-1];
            twister_q[n] = MUL_SEED_K * (p ^ (p >> 62)) + 64'(n);
        end
        word_ptr = STATE_WORDS;
    endfunction

    function automatic void fill_from_keys();
        int unsigned i, j, k, len;
        logic [63:0] p;
        i = 1;
        j = 0;
        len = key_fill;
        fill_from_seed(KEY_BASE_SEED);
        k = (len > STATE_WORDS) ? len : STATE_WORDS;
        for (; k > 0; k--) begin
            p = twister_q[i-1];
            twister_q[i] = (twister_q[i] ^ ((p ^ (p >> 62)) * MUL_KEY1_K))
                           + key_words[j] + 64'(j);
            i++;
            j++;
            if (i >= STATE_WORDS) begin
                twister_q[0] = twister_q[STATE_WORDS-1];
                i = 1;
            end
            if (j >= len) j = 0;
        end
        for (k = STATE_WORDS - 1; k > 0; k--) begin
            p = twister_q[i-1];
            twister_q[i] = (twister_q[i] ^ ((p ^ (p >> 62)) * MUL_KEY2_K)) - 64'(i);
            i++;
            if (i >= STATE_WORDS) begin
                twister_q[0] = twister_q[STATE_WORDS-1];
                i = 1;
            end
        end
        twister_q[0] = KEY_FINAL_W0;
        word_ptr = STATE_WORDS;
    endfunction

    function automatic void twist_state();
        logic [63:0] x;
        int unsigned nx, fr;
        for (int n = 0; n < STATE_WORDS; n++) begin
            nx = (n + 1) % STATE_WORDS;
            fr = (n + MID_OFFSET) % STATE_WORDS;
            x = (twister_q[n] & UPPER_BITS) | (twister_q[nx] & LOWER_BITS);
            twister_q[n] = twister_q[fr] ^ (x >> 1) ^ (x[0] ? TWIST_MATRIX : 64'd0);
        end
        word_ptr = 0;
    endfunction

    function automatic logic [63:0] draw_word();
        logic [63:0] x;
        if (word_ptr >= STATE_WORDS) begin
            // unseeded: fall back to the default seed first
            if (word_ptr != STATE_WORDS) fill_from_seed(DEFAULT_SEED);
            twist_state();
        end
        x = twister_q[word_ptr];
        word_ptr++;
        x ^= (x >> 29) & TEMPER_B;
        x ^= (x << 17) & TEMPER_C;
        x ^= (x << 37) & TEMPER_D;
        x ^= (x >> 43);
        return x;
    endfunction

    // Advance the shadow generator by one accepted item
    function automatic void predict_item(input t_command cmd, input logic [63:0] value);
        case (cmd)
            CMD_SEED: begin
                fill_from_seed(value);
            end
            CMD_LOAD_KEY: begin
                if (key_fill < KEY_CAP) begin
                    key_words[key_fill] = value;
                    key_fill++;
                end
            end
            CMD_APPLY_KEY: begin
                if (key_fill > 0) begin
                    fill_from_keys();
                    key_fill = 0;
                end
            end
            default: begin
                expected_words.push_back(draw_word());
            end
        endcase
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(7))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_item(input t_command cmd, input logic [63:0] value);
        request_queue.push_back('{cmd: cmd, value: value});
    endtask

    task automatic queue_generates(input int count);
        for (int n = 0; n < count; n++) queue_item(CMD_GENERATE, pick_value());
    endtask

    task automatic queue_key_run(input int count);
        for (int n = 0; n < count; n++) queue_item(CMD_LOAD_KEY, pick_value());
        queue_item(CMD_APPLY_KEY, pick_value());
    endtask

    task automatic report_mismatch(input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at %0t: random_word got %h expected %h", $realtime, got, want);
        error_count++;
    endtask

    // Idling phase rotates every 60 accepted items: none, sender, receiver, both
    function automatic int sender_idle_pct();
        case ((accepted_count / 60) % 4)
            1: return 74;
            3: return 7;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case ((accepted_count / 60) % 4)
            2: return 74;
            3: return 7;
            default: return 0;
        endcase
    endfunction

    // Driver: hold the item until accepted, then present the next one or idle
    always @(posedge i_clk) begin
        t_request req;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_item(s_cmd, s_data);
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (request_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
                    req = request_queue.pop_front();
                    s_valid <= 1'b1;
                    s_cmd   <= req.cmd;
                    s_data  <= req.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted word against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("unexpected word %h at %0t", m_data, $realtime);
                    error_count++;
                end else begin
                    if (m_data !== expected_words[0]) report_mismatch(m_data, expected_words[0]);
                    void'(expected_words.pop_front());
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    // Watchdog: drop the run when no handshake happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[mersenne_twister_64_generator] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int total;
        int pick;
        word_ptr = STATE_WORDS + 1;
        key_fill = 0;

        // Directed: default seed, empty apply, value extremes, short key runs
        queue_generates(3);
        queue_item(CMD_APPLY_KEY, 64'd0);
        queue_generates(1);
        queue_item(CMD_SEED, 64'd0);
        queue_generates(2);
        queue_item(CMD_SEED, '1);
        queue_generates(2);
        queue_item(CMD_LOAD_KEY, '1);
        queue_item(CMD_LOAD_KEY, 64'd0);
        queue_item(CMD_APPLY_KEY, '1);
        queue_generates(2);
        queue_item(CMD_SEED, 64'h5555555555555555);
        queue_generates(1);
        queue_key_run(1);
        queue_generates(2);

        // Random: mostly generate runs, long runs to cross the re-twist, key runs
        total = 0;
        queue_generates(330);
        total += 330;
        while (total < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                pick = $urandom_range(1, 40);
                queue_generates(pick);
                total += pick;
            end else if (pick < 72) begin
                queue_item(CMD_SEED, pick_value());
                queue_generates(3);
                total += 4;
            end else if (pick < 88) begin
                pick = $urandom_range(1, 8);
                queue_key_run(pick);
                queue_generates(3);
                total += pick + 4;
            end else if (pick < 94) begin
                queue_item(CMD_APPLY_KEY, pick_value());
                total += 1;
            end else begin
                queue_item(CMD_LOAD_KEY, pick_value());
                total += 1;
            end
        end
        // Overfill the key store so the tail words are dropped
        queue_key_run(KEY_CAP + 3);
        queue_generates(20);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() > 0 || s_valid) @(posedge i_clk);
        while (expected_words.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("[mersenne_twister_64_generator] OK");
        end else begin
            $display("[mersenne_twister_64_generator] ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/mt64_pkg.sv
hw/rtl/mt64_ram.sv
hw/rtl/mt64_mul.sv
hw/rtl/mt64_datapath.sv
hw/rtl/mt64_ctrl.sv
hw/rtl/mersenne_twister_64_generator.sv
tb/testbench.sv
